// File: hdl/isd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// isd_pkg: shared types and codes for the isolation distance block
// Opcodes, status codes, register indexes and the chain control bundle.
// ---------------------------------------------------------------------------
package isd_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_MATRIX = 2'd0,
    OP_LOAD_MEAN   = 2'd1,
    OP_FEATURE     = 2'd2,
    OP_FINISH      = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SMALL     = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_FEW_DIST  = 2'd3
  } status_t;

  localparam logic [1:0] REG_TARGET = 2'd0;
  localparam logic [1:0] REG_CSIZE  = 2'd1;
  localparam logic [1:0] REG_DIMS   = 2'd2;

  localparam int DIST_W = 48;

  typedef struct packed {
    logic              insert;
    logic              clear;
    logic [DIST_W-1:0] dval;
  } chain_ctrl_t;

endpackage
`default_nettype wire

// File: hdl/isd_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// isd_cell: one slot of the sorted distance chain
// Keeps its value, takes the new item or its lower neighbor's value on insert.
// ---------------------------------------------------------------------------
module isd_cell (
  input  wire logic                      clk,
  input  wire logic                      insert,
  input  wire logic [isd_pkg::DIST_W-1:0] new_val,
  input  wire logic                      own_valid,
  input  wire logic                      prev_gt,
  input  wire logic [isd_pkg::DIST_W-1:0] prev_val,
  output logic      [isd_pkg::DIST_W-1:0] val,
  output logic                           gt
);
  import isd_pkg::*;

  logic [DIST_W-1:0] val_r;

  // an empty slot counts as larger than anything
  assign gt  = !own_valid || (val_r > new_val);
  assign val = val_r;

  // shift down from the neighbor, or take the new distance at the insert point
  always_ff @(posedge clk) begin
    if (insert && gt) begin
      val_r <= prev_gt ? prev_val : new_val;
    end
  end

endmodule
`default_nettype wire

// File: hdl/isd_chain.sv
`default_nettype none
// ---------------------------------------------------------------------------
// isd_chain: row of cells holding the smallest distances in ascending order
// One insert per cycle; the largest value drops off the end when full.
// ---------------------------------------------------------------------------
module isd_chain #(
  parameter int MAX_RANK = 256,
  parameter int RIW      = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1,
  parameter int FW       = $clog2(MAX_RANK + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire isd_pkg::chain_ctrl_t      ctrl,
  input  wire logic [RIW-1:0]            rd_idx,
  output logic      [isd_pkg::DIST_W-1:0] rd_val,
  output logic      [FW-1:0]             fill
);
  import isd_pkg::*;

  logic [FW-1:0]     fill_r;
  logic [DIST_W-1:0] vals [MAX_RANK];
  logic              gts  [MAX_RANK];

  // count filled slots
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      fill_r <= '0;
    end else if (ctrl.insert && (32'(fill_r) < MAX_RANK)) begin
      fill_r <= fill_r + FW'(1);
    end
  end

  for (genvar i = 0; i < MAX_RANK; i++) begin : g_cell
    logic              pgt;
    logic [DIST_W-1:0] pval;
    if (i == 0) begin : g_head
      assign pgt  = 1'b0;
      assign pval = '0;
    end else begin : g_body
      assign pgt  = gts[i-1];
      assign pval = vals[i-1];
    end
    isd_cell u_cell (
      .clk       (clk),
      .insert    (ctrl.insert),
      .new_val   (ctrl.dval),
      .own_valid (32'(fill_r) > i),
      .prev_gt   (pgt),
      .prev_val  (pval),
      .val       (vals[i]),
      .gt        (gts[i])
    );
  end

  assign rd_val = vals[rd_idx];
  assign fill   = fill_r;

endmodule
`default_nettype wire

// File: hdl/isolation_distance_select.sv
`default_nettype none
// ---------------------------------------------------------------------------
// isolation_distance_select: isolation distance of one cluster
// Software sets target_cluster, cluster_size and dim_count over the APB port,
// then loads the inverse covariance (opcode 0) and mean (opcode 1) items.
// Points follow one feature per item (opcode 2); a finish item (opcode 3)
// returns one result: the cluster_size-th smallest squared distance of the
// points outside the cluster, a status and the kept and dropped counts.
// A feature item at element index e runs 1 + 2e products, each in three
// steps (matrix read, multiply, saturating add), then a close step. A kept
// distance enters the cell chain in the close step. A finish item shows
// its result on the cycle after it is accepted. The result register holds
// while out_stall is high; input is stalled only while an element is in
// work or a result is held back. Reset clears counters, chain fill, the
// sequencer, the configuration and the output valid flag; matrix and mean
// hold until loaded. There is no clearing pass.
// ---------------------------------------------------------------------------
module isolation_distance_select #(
  parameter int MAX_DIMS   = 16,
  parameter int MAX_RANK   = 256,
  parameter int COUNT_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [3:0]         in_row_index,
  input  wire logic [3:0]         in_col_index,
  input  wire logic signed [31:0] in_matrix_value,
  input  wire logic signed [15:0] in_feature_value,
  input  wire logic [7:0]         in_point_label,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [47:0]             out_isolation_distance,
  output logic [1:0]              out_status,
  output logic [15:0]             out_outside_count,
  output logic [15:0]             out_dropped_count,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import isd_pkg::*;

  localparam int IW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CW  = $clog2(MAX_DIMS + 1);
  localparam int RIW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int FW  = $clog2(MAX_RANK + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_MUL   = 5'b00100,
    S_ACC   = 5'b01000,
    S_CLOSE = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    T_DIAG  = 2'd0,
    T_UPPER = 2'd1,
    T_LOWER = 2'd2
  } term_t;

  state_t state_r;
  term_t  term_r;

  logic [7:0]            target_r;
  logic [8:0]            csize_r;
  logic [4:0]            dimc_r;
  logic signed [15:0]    mean_r [MAX_DIMS];
  logic signed [16:0]    cent_r [MAX_DIMS];
  logic signed [31:0]    icov_mem [2**(2*IW)];
  logic signed [31:0]    rd_r;
  logic signed [33:0]    cc_r;
  logic signed [63:0]    prod_r;
  logic signed [63:0]    accum_r;
  logic signed [16:0]    c_r;
  logic [IW-1:0]         e_r;
  logic [IW-1:0]         j_r;
  logic [CW-1:0]         ecnt_r;
  logic [7:0]            held_r;
  logic [COUNT_BITS-1:0] total_r;
  logic [COUNT_BITS-1:0] kept_r;
  logic [COUNT_BITS-1:0] neg_r;
  logic                  out_valid_r;
  logic [47:0]           out_dist_r;
  logic [1:0]            out_status_r;
  logic [15:0]           out_kept_r;
  logic [15:0]           out_neg_r;

  logic                  in_acc;
  logic                  cfg_wr;
  opcode_t               op;
  logic [CW-1:0]         dims;
  logic [IW-1:0]         e_new;
  logic signed [16:0]    c_new;
  logic signed [16:0]    mul_a;
  logic [2*IW-1:0]       rd_addr;
  logic signed [65:0]    prod_full;
  logic signed [64:0]    sum;
  logic signed [63:0]    accum_sat;
  logic [CW-1:0]         ecnt_inc;
  logic                  point_done;
  logic [1:0]            status_new;
  chain_ctrl_t           chain_ctrl;
  logic [DIST_W-1:0]     chain_rd;
  logic [FW-1:0]         chain_fill;

  assign op       = opcode_t'(in_opcode);
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      csize_r  <= '0;
      dimc_r   <= 5'd1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_TARGET: target_r <= pwdata[7:0];
        REG_CSIZE:  csize_r  <= pwdata[8:0];
        REG_DIMS:   dimc_r   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TARGET: prdata = 32'(target_r);
      REG_CSIZE:  prdata = 32'(csize_r);
      REG_DIMS:   prdata = 32'(dimc_r);
      default:    prdata = '0;
    endcase
  end

  // effective dimension count and element index
  always_comb begin
    if (dimc_r == '0) begin
      dims = CW'(1);
    end else if (32'(dimc_r) > MAX_DIMS) begin
      dims = CW'(MAX_DIMS);
    end else begin
      dims = CW'(dimc_r);
    end
    e_new = (32'(ecnt_r) >= MAX_DIMS) ? IW'(MAX_DIMS - 1) : IW'(ecnt_r);
    c_new = 17'(in_feature_value) - 17'(mean_r[e_new]);
  end

  // inverse covariance memory
  always_ff @(posedge clk) begin
    if (in_acc && (op == OP_LOAD_MATRIX) && (32'(in_row_index) < MAX_DIMS) &&
        (32'(in_col_index) < MAX_DIMS)) begin
      icov_mem[{IW'(in_row_index), IW'(in_col_index)}] <= in_matrix_value;
    end
    if (state_r == S_FETCH) begin
      rd_r <= icov_mem[rd_addr];
    end
  end

  // product operands and saturating sum
  always_comb begin
    case (term_r)
      T_DIAG:  rd_addr = {e_r, e_r};
      T_UPPER: rd_addr = {j_r, e_r};
      T_LOWER: rd_addr = {e_r, j_r};
      default: rd_addr = {e_r, e_r};
    endcase
    mul_a     = (term_r == T_DIAG) ? c_r : cent_r[j_r];
    prod_full = cc_r * rd_r;
    sum       = {accum_r[63], accum_r} + {prod_r[63], prod_r};
    if (sum[64] != sum[63]) begin
      accum_sat = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      accum_sat = sum[63:0];
    end
    ecnt_inc   = CW'(e_r) + CW'(1);
    point_done = ecnt_inc >= dims;
  end

  // finish status
  always_comb begin
    if (csize_r < 9'd2) begin
      status_new = ST_SMALL;
    end else if (32'({csize_r, 1'b0}) >= 32'(total_r)) begin
      status_new = ST_TOO_LARGE;
    end else if ((32'(csize_r) > 32'(kept_r)) || (32'(csize_r) > MAX_RANK) ||
                 (32'(csize_r) > 32'(chain_fill))) begin
      status_new = ST_FEW_DIST;
    end else begin
      status_new = ST_OK;
    end
  end

  // chain control
  always_comb begin
    chain_ctrl.insert = (state_r == S_CLOSE) && point_done && (held_r != target_r) &&
                        !accum_r[63];
    chain_ctrl.clear  = in_acc && (op == OP_FINISH);
    chain_ctrl.dval   = DIST_W'(accum_r[63:24]);
  end

  isd_chain #(
    .MAX_RANK (MAX_RANK),
    .RIW      (RIW),
    .FW       (FW)
  ) u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (chain_ctrl),
    .rd_idx (RIW'(csize_r - 9'd1)),
    .rd_val (chain_rd),
    .fill   (chain_fill)
  );

  // mean and centered element storage
  always_ff @(posedge clk) begin
    if (in_acc && (op == OP_LOAD_MEAN) && (32'(in_row_index) < MAX_DIMS)) begin
      mean_r[IW'(in_row_index)] <= in_feature_value;
    end
    if (in_acc && (op == OP_FEATURE)) begin
      cent_r[e_new] <= c_new;
      c_r           <= c_new;
      e_r           <= e_new;
    end
    if (state_r == S_FETCH) begin
      cc_r <= 34'(mul_a) * 34'(c_r);
    end
    if (state_r == S_MUL) begin
      prod_r <= prod_full[63:0];
    end
  end

  // term sequencer and point bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      term_r  <= T_DIAG;
      j_r     <= '0;
      accum_r <= '0;
      ecnt_r  <= '0;
      held_r  <= '0;
      total_r <= '0;
      kept_r  <= '0;
      neg_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc && (op == OP_FEATURE)) begin
            if (e_new == '0) begin
              held_r  <= in_point_label;
              accum_r <= '0;
            end
            term_r  <= T_DIAG;
            j_r     <= '0;
            state_r <= S_FETCH;
          end else if (in_acc && (op == OP_FINISH)) begin
            accum_r <= '0;
            ecnt_r  <= '0;
            held_r  <= '0;
            total_r <= '0;
            kept_r  <= '0;
            neg_r   <= '0;
          end
        end
        S_FETCH: state_r <= S_MUL;
        S_MUL:   state_r <= S_ACC;
        S_ACC: begin
          accum_r <= accum_sat;
          state_r <= S_FETCH;
          case (term_r)
            T_DIAG: begin
              if (e_r == '0) begin
                state_r <= S_CLOSE;
              end else begin
                term_r <= T_UPPER;
              end
            end
            T_UPPER: term_r <= T_LOWER;
            default: begin
              if (j_r == e_r - IW'(1)) begin
                state_r <= S_CLOSE;
              end else begin
                j_r    <= j_r + IW'(1);
                term_r <= T_UPPER;
              end
            end
          endcase
        end
        S_CLOSE: begin
          if (point_done) begin
            ecnt_r  <= '0;
            accum_r <= '0;
            if (total_r != CNT_MAX) total_r <= total_r + 1'b1;
            if (held_r != target_r) begin
              if (accum_r[63]) begin
                if (neg_r != CNT_MAX) neg_r <= neg_r + 1'b1;
              end else if (kept_r != CNT_MAX) begin
                kept_r <= kept_r + 1'b1;
              end
            end
          end else begin
            ecnt_r <= ecnt_inc;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && (op == OP_FINISH)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (in_acc && (op == OP_FINISH)) begin
      out_status_r <= status_new;
      out_dist_r   <= (status_new == ST_OK) ? chain_rd : '0;
      out_kept_r   <= 16'(kept_r);
      out_neg_r    <= 16'(neg_r);
    end
  end

  assign out_valid              = out_valid_r;
  assign out_isolation_distance = out_dist_r;
  assign out_status             = out_status_r;
  assign out_outside_count      = out_kept_r;
  assign out_dropped_count      = out_neg_r;

  // a failed status never carries a distance
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_isolation_distance == '0)
    else $error("distance set with error status");

  // the chain never counts past its depth
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    32'(chain_fill) <= MAX_RANK)
    else $error("chain fill beyond depth");

  // a matrix read is always followed by the multiply
  a_fetch_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH) |=> (state_r == S_MUL))
    else $error("sequencer skipped multiply");

  // the chain only grows on a closed point
  a_fill_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (chain_fill != $past(chain_fill)) && (chain_fill != '0) |->
      ($past(state_r) == S_CLOSE))
    else $error("chain grew outside point close");

endmodule
`default_nettype wire
